// File: src/gpioc_pkg.sv
// Package for the two-bank GPIO controller: request and result structs,
// operation and register codes, bank geometry. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gpioc_pkg;

    localparam int unsigned PIN_COUNT  = 32;
    localparam int unsigned BANK_WIDTH = 16;

    // Pins that belong to bank 0; with a full-width bank 0 the mask is all ones.
    localparam logic [PIN_COUNT-1:0] BANK0_MASK = (BANK_WIDTH >= PIN_COUNT) ?
        {PIN_COUNT{1'b1}} :
        ((PIN_COUNT'(1) << BANK_WIDTH) - PIN_COUNT'(1));

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    localparam logic [3:0] REG_DIR      = 4'd0;
    localparam logic [3:0] REG_OUT      = 4'd1;
    localparam logic [3:0] REG_SET      = 4'd2;
    localparam logic [3:0] REG_CLR      = 4'd3;
    localparam logic [3:0] REG_IN       = 4'd4;
    localparam logic [3:0] REG_SETRISE  = 4'd5;
    localparam logic [3:0] REG_CLRRISE  = 4'd6;
    localparam logic [3:0] REG_SETFALL  = 4'd7;
    localparam logic [3:0] REG_CLRFALL  = 4'd8;
    localparam logic [3:0] REG_INTSTAT  = 4'd9;
    localparam logic [3:0] REG_BANK_EN  = 4'd10;

    typedef struct packed {
        logic [1:0]           op;
        logic [3:0]           reg_index;
        logic [PIN_COUNT-1:0] write_data;
        logic [PIN_COUNT-1:0] pin_levels;
    } t_in;

    typedef struct packed {
        logic [PIN_COUNT-1:0] read_data;
        logic [PIN_COUNT-1:0] pin_drive;
        logic [PIN_COUNT-1:0] pin_output_enable;
        logic [1:0]           bank_irq;
    } t_out;

endpackage
`default_nettype wire

// File: src/gpio_controller_with_edge_irq_unit.sv
// Top level of the two-bank GPIO controller with edge interrupts.
// Depends on gpioc_pkg for the request/result structs and register codes.
// Each result is registered into the output register, or into the skid entry when the output holds a waiting result.
// Throughput: one request per cycle while the skid entry is empty; register file and edge logic update in one pass.
// A two-entry result stage (output register plus skid) keeps the input side open
// for one more request while a result waits on the output.
// Reset (synchronous, active low): all pins inputs, latch, enables, status and
// previous levels cleared, result stage empty.
`timescale 1ns / 1ps
`default_nettype none
module gpio_controller_with_edge_irq_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire gpioc_pkg::t_in i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output gpioc_pkg::t_out     o_out_data
);

    localparam int unsigned W = gpioc_pkg::PIN_COUNT;

    logic [W-1:0] r_dir, n_dir;
    logic [W-1:0] r_latch, n_latch;
    logic [W-1:0] r_rise_en, n_rise_en;
    logic [W-1:0] r_fall_en, n_fall_en;
    logic [W-1:0] r_status, n_status;
    logic [W-1:0] r_last;
    logic [1:0]   r_bank_en, n_bank_en;

    logic [W-1:0] edges;
    logic [W-1:0] clear;
    logic [W-1:0] rd;
    logic         is_write;
    logic         push;
    logic         pop;

    gpioc_pkg::t_out n_result;
    gpioc_pkg::t_out r_skid;
    logic            r_skid_valid;

    assign o_in_ready = !r_skid_valid;
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_out_valid && i_out_ready;
    assign is_write   = (i_in_data.op == gpioc_pkg::OP_WRITE);

    // Edges are qualified by the enables as they stand before this request.
    assign edges = ((i_in_data.pin_levels & ~r_last) & r_rise_en) |
                   ((~i_in_data.pin_levels & r_last) & r_fall_en);

    always_comb begin
        rd = '0;
        if (i_in_data.op == gpioc_pkg::OP_READ) begin
            unique case (i_in_data.reg_index) inside
                gpioc_pkg::REG_DIR: rd = r_dir;
                gpioc_pkg::REG_OUT, gpioc_pkg::REG_SET, gpioc_pkg::REG_CLR: rd = r_latch;
                gpioc_pkg::REG_IN: rd = i_in_data.pin_levels;
                gpioc_pkg::REG_SETRISE, gpioc_pkg::REG_CLRRISE: rd = r_rise_en;
                gpioc_pkg::REG_SETFALL, gpioc_pkg::REG_CLRFALL: rd = r_fall_en;
                gpioc_pkg::REG_INTSTAT: rd = r_status;
                gpioc_pkg::REG_BANK_EN: rd = {{(W-2){1'b0}}, r_bank_en};
                default: rd = '0;
            endcase
        end
    end

    always_comb begin
        n_dir     = r_dir;
        n_latch   = r_latch;
        n_rise_en = r_rise_en;
        n_fall_en = r_fall_en;
        n_bank_en = r_bank_en;
        clear     = '0;
        if (is_write) begin
            unique case (i_in_data.reg_index)
                gpioc_pkg::REG_DIR:     n_dir     = i_in_data.write_data;
                gpioc_pkg::REG_OUT:     n_latch   = i_in_data.write_data;
                gpioc_pkg::REG_SET:     n_latch   = r_latch | i_in_data.write_data;
                gpioc_pkg::REG_CLR:     n_latch   = r_latch & ~i_in_data.write_data;
                gpioc_pkg::REG_SETRISE: n_rise_en = r_rise_en | i_in_data.write_data;
                gpioc_pkg::REG_CLRRISE: n_rise_en = r_rise_en & ~i_in_data.write_data;
                gpioc_pkg::REG_SETFALL: n_fall_en = r_fall_en | i_in_data.write_data;
                gpioc_pkg::REG_CLRFALL: n_fall_en = r_fall_en & ~i_in_data.write_data;
                gpioc_pkg::REG_INTSTAT: clear     = i_in_data.write_data;
                gpioc_pkg::REG_BANK_EN: n_bank_en = i_in_data.write_data[1:0];
                default: ;
            endcase
        end
        // A new edge wins over a clear.
        n_status = (r_status & ~clear) | edges;

        n_result.read_data         = rd;
        n_result.pin_drive         = n_latch;
        n_result.pin_output_enable = ~n_dir;
        n_result.bank_irq[0]       = (|(n_status & gpioc_pkg::BANK0_MASK)) && n_bank_en[0];
        n_result.bank_irq[1]       = (|(n_status & ~gpioc_pkg::BANK0_MASK)) && n_bank_en[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir     <= '1;
            r_latch   <= '0;
            r_rise_en <= '0;
            r_fall_en <= '0;
            r_status  <= '0;
            r_last    <= '0;
            r_bank_en <= '0;
        end else if (push) begin
            r_dir     <= n_dir;
            r_latch   <= n_latch;
            r_rise_en <= n_rise_en;
            r_fall_en <= n_fall_en;
            r_status  <= n_status;
            r_last    <= i_in_data.pin_levels;
            r_bank_en <= n_bank_en;
        end
    end

    // Result stage: output register, with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                o_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                o_out_valid <= push;
            end
        end else if (push) begin
            if (!o_out_valid) begin
                o_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            o_out_data <= r_skid;
        end else if (push && (pop || !o_out_valid)) begin
            o_out_data <= n_result;
        end
        if (push && o_out_valid && !pop) begin
            r_skid <= n_result;
        end
    end

    a_skid_behind_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> o_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost while output stalled");

    a_dir_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && is_write && i_in_data.reg_index == gpioc_pkg::REG_DIR)
        |=> (r_dir == $past(i_in_data.write_data)))
        else $error("direction write not taken");

    a_idle_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !push |=> ($stable(r_status) && $stable(r_latch) && $stable(r_last)))
        else $error("state changed without a request");

endmodule
`default_nettype wire

// File: dv/tb_gpio_controller_with_edge_irq_unit.sv
// Self-checking testbench for gpio_controller_with_edge_irq_unit.
// Depends on gpioc_pkg; predicts each result from its own copy of the register
// state and compares it field by field, under several handshake stall mixes.
`timescale 1ns / 1ps
module tb_gpio_controller_with_edge_irq_unit;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [3:0] REG_SPARE_LO   = 4'd11;
    localparam logic [3:0] REG_SPARE_HI   = 4'd15;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         PHASE_ITEMS    = 170;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    gpioc_pkg::t_in  i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    gpioc_pkg::t_out o_out_data;

    gpio_controller_with_edge_irq_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted register state
    logic [31:0] dir_bits;
    logic [31:0] latch_bits;
    logic [31:0] rise_en_bits;
    logic [31:0] fall_en_bits;
    logic [31:0] status_bits;
    logic [31:0] prev_pins;
    logic [1:0]  bank_en_bits;

    gpioc_pkg::t_out expected_results[$];
    logic [31:0]     pin_state;
    int              sender_idle_pct;
    int              receiver_stall_pct;
    int              requests_sent;
    int              results_checked;
    int              error_count;
    int              stall_cycles;

    function automatic void reset_gpio_model();
        dir_bits     = '1;
        latch_bits   = '0;
        rise_en_bits = '0;
        fall_en_bits = '0;
        status_bits  = '0;
        prev_pins    = '0;
        bank_en_bits = '0;
    endfunction

    function automatic gpioc_pkg::t_out predict_gpio_step(input gpioc_pkg::t_in req);
        gpioc_pkg::t_out res;
        logic [31:0]     edges;
        logic [31:0]     clear_mask;
        logic [31:0]     rd;
        edges = (req.pin_levels & ~prev_pins & rise_en_bits) |
                (~req.pin_levels & prev_pins & fall_en_bits);
        clear_mask = '0;
        rd = '0;
        // Reads see the registers as they stood before this request
        if (req.op == gpioc_pkg::OP_READ) begin
            case (req.reg_index) inside
                gpioc_pkg::REG_DIR: rd = dir_bits;
                gpioc_pkg::REG_OUT, gpioc_pkg::REG_SET, gpioc_pkg::REG_CLR: rd = latch_bits;
                gpioc_pkg::REG_IN: rd = req.pin_levels;
                gpioc_pkg::REG_SETRISE, gpioc_pkg::REG_CLRRISE: rd = rise_en_bits;
                gpioc_pkg::REG_SETFALL, gpioc_pkg::REG_CLRFALL: rd = fall_en_bits;
                gpioc_pkg::REG_INTSTAT: rd = status_bits;
                gpioc_pkg::REG_BANK_EN: rd = {30'd0, bank_en_bits};
                default: rd = '0;
            endcase
        end
        if (req.op == gpioc_pkg::OP_WRITE) begin
            case (req.reg_index)
                gpioc_pkg::REG_DIR:     dir_bits     = req.write_data;
                gpioc_pkg::REG_OUT:     latch_bits   = req.write_data;
                gpioc_pkg::REG_SET:     latch_bits   = latch_bits | req.write_data;
                gpioc_pkg::REG_CLR:     latch_bits   = latch_bits & ~req.write_data;
                gpioc_pkg::REG_SETRISE: rise_en_bits = rise_en_bits | req.write_data;
                gpioc_pkg::REG_CLRRISE: rise_en_bits = rise_en_bits & ~req.write_data;
                gpioc_pkg::REG_SETFALL: fall_en_bits = fall_en_bits | req.write_data;
                gpioc_pkg::REG_CLRFALL: fall_en_bits = fall_en_bits & ~req.write_data;
                gpioc_pkg::REG_INTSTAT: clear_mask   = req.write_data;
                gpioc_pkg::REG_BANK_EN: bank_en_bits = req.write_data[1:0];
                default: ;
            endcase
        end
        // A fresh edge beats a clear in the same request
        status_bits = (status_bits & ~clear_mask) | edges;
        prev_pins   = req.pin_levels;
        res.read_data         = rd;
        res.pin_drive         = latch_bits;
        res.pin_output_enable = ~dir_bits;
        res.bank_irq[0] = (|(status_bits & gpioc_pkg::BANK0_MASK)) && bank_en_bits[0];
        res.bank_irq[1] = (|(status_bits & ~gpioc_pkg::BANK0_MASK)) && bank_en_bits[1];
        return res;
    endfunction

    function automatic gpioc_pkg::t_in pack_request(input logic [1:0] op,
                                                    input logic [3:0] idx,
                                                    input logic [31:0] data,
                                                    input logic [31:0] pins);
        gpioc_pkg::t_in req;
        req.op         = op;
        req.reg_index  = idx;
        req.write_data = data;
        req.pin_levels = pins;
        return req;
    endfunction

    // Drop valid only when a gap is taken, so valid never falls and rises in one step
    task automatic send_request(input gpioc_pkg::t_in req);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_results.push_back(predict_gpio_step(req));
        requests_sent++;
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Result side: random stalls, checking and the watchdog
    always @(posedge i_clk) begin
        gpioc_pkg::t_out exp_res;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request outstanding, got %h", $time, o_out_data);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                compare_field("read_data", exp_res.read_data, o_out_data.read_data);
                compare_field("pin_drive", exp_res.pin_drive, o_out_data.pin_drive);
                compare_field("pin_output_enable", exp_res.pin_output_enable,
                              o_out_data.pin_output_enable);
                compare_field("bank_irq", {30'd0, exp_res.bank_irq},
                              {30'd0, o_out_data.bank_irq});
                results_checked++;
            end
        end
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_register_defaults();
        send_request(pack_request(gpioc_pkg::OP_READ, gpioc_pkg::REG_DIR, '0, '0));
        send_request(pack_request(gpioc_pkg::OP_READ, gpioc_pkg::REG_BANK_EN, '0, '0));
        send_request(pack_request(gpioc_pkg::OP_WRITE, REG_SPARE_LO, '1, '0));
        send_request(pack_request(gpioc_pkg::OP_READ, REG_SPARE_HI, '0, '0));
        // Op 3 behaves as a plain pin sample; the write fields must be ignored
        send_request(pack_request(OP_UNUSED, gpioc_pkg::REG_DIR, '0, '0));
        send_request(pack_request(gpioc_pkg::OP_READ, gpioc_pkg::REG_DIR, '0, '0));
    endtask

    task automatic test_latch_and_direction();
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_DIR, 32'h0000_ffff, '0));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_OUT, '1, '0));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_CLR, 32'h0f0f_0f0f, '0));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_SET, 32'h8000_0001, '0));
        send_request(pack_request(gpioc_pkg::OP_READ, gpioc_pkg::REG_CLR, '0, '0));
        send_request(pack_request(gpioc_pkg::OP_READ, gpioc_pkg::REG_IN, '0, 32'ha5a5_5a5a));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_IN, '1, 32'h5a5a_a5a5));
    endtask

    task automatic test_edge_interrupts();
        send_request(pack_request(gpioc_pkg::OP_SAMPLE, gpioc_pkg::REG_DIR, '0, '0));
        // Enables written in the same request must not qualify its edges
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_SETRISE, '1, '1));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_SETFALL, '1, '0));
        // Extra bank enable bits are dropped
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_BANK_EN,
                                  32'hffff_fffc, '1));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_BANK_EN,
                                  32'h0000_0003, '1));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_INTSTAT, '1, '0));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_INTSTAT,
                                  32'h0000_ffff, '0));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_CLRRISE,
                                  32'hffff_0000, 32'hffff_0000));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_CLRFALL,
                                  32'h0000_ffff, '0));
        send_request(pack_request(gpioc_pkg::OP_WRITE, gpioc_pkg::REG_INTSTAT, '1, '0));
        send_request(pack_request(gpioc_pkg::OP_READ, gpioc_pkg::REG_CLRRISE,
                                  '0, 32'h0000_0001));
        send_request(pack_request(gpioc_pkg::OP_READ, gpioc_pkg::REG_SETFALL, '0, '0));
    endtask

    function automatic gpioc_pkg::t_in random_request();
        gpioc_pkg::t_in req;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 38)      req.op = gpioc_pkg::OP_SAMPLE;
        else if (pick < 62) req.op = gpioc_pkg::OP_READ;
        else if (pick < 97) req.op = gpioc_pkg::OP_WRITE;
        else                req.op = OP_UNUSED;
        if ($urandom_range(99) < 93)
            req.reg_index = 4'($urandom_range(10));
        else
            req.reg_index = 4'($urandom_range(15, 11));
        case ($urandom_range(4))
            0:       req.write_data = '1;
            1:       req.write_data = '0;
            2:       req.write_data = 32'd1 << $urandom_range(31);
            3:       req.write_data = $urandom() & $urandom();
            default: req.write_data = $urandom();
        endcase
        // Mostly sparse toggles so edges stay readable, with some full reshuffles
        pick = $urandom_range(99);
        if (pick < 50)      pin_state = pin_state ^ ($urandom() & $urandom() & $urandom());
        else if (pick < 75) pin_state = $urandom();
        req.pin_levels = pin_state;
        return req;
    endfunction

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_request(random_request());
        // Let the output side empty before the next mix
        hold_until_drained();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_in_data          = '0;
        i_out_ready        = 1'b0;
        pin_state          = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        requests_sent      = 0;
        results_checked    = 0;
        error_count        = 0;
        stall_cycles       = 0;
        reset_gpio_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_defaults();
        test_latch_and_direction();
        test_edge_interrupts();
        hold_until_drained();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 88, 0);
        test_random_traffic(PHASE_ITEMS, 0, 88);
        test_random_traffic(PHASE_ITEMS, 29, 29);

        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            error_count++;
        end
        $display("Sent %0d requests (directed register and edge cases, then four stall mixes);",
                 requests_sent);
        $display("checked %0d results, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
